>>> hdl/iirdf1_pkg.sv
// shared types, codes and constants of the direct-form-one iir filter
package iirdf1_pkg;

   localparam int DATA_W       = 32;
   localparam int TAP_CFG_W    = 7;
   localparam int DEF_MAX_TAPS = 64;

   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_B_COEF = 2'd1;
   localparam logic [1:0] KIND_A_COEF = 2'd2;
   localparam logic [1:0] KIND_CLEAR  = 2'd3;

   typedef struct packed {
      logic [1:0]               kind;
      logic signed [DATA_W-1:0] sample;
      logic [5:0]               coef_index;
      logic signed [DATA_W-1:0] coef_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] filtered;
      logic                     saturated;
      logic                     zero_divisor;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] divisor;
   } div_ctl_type;

endpackage

>>> hdl/iir_filter_direct_form_one_top.sv
// top level of the direct-form-one iir filter: sequencer, multiply-accumulate and result stage
//
// A sample item writes x[n] into the input ring, then one shared 32x32 multiplier walks both
// rings: b[i]*x[n-i] for i = 0..L-1, then a[i]*y[n-i] for i = 1..L-1, reading one history word
// and one coefficient word per cycle from two synchronous memories. The sum sits in an
// accumulator of 64 + clog2(2*MAX_TAPS) bits and is divided by a[0] in a one-bit-per-cycle
// restoring divider, truncated toward zero and clipped to 32 bits. The time a sample takes
// grows with L, the tap count in use, through the walk over the memories, and with ACC_W (71
// at 64 taps) through the divider. Coefficient and clear items do not leave the idle state.
// a[0] = 0 gives 0 with zero_divisor. The result sits in an output register, so the next item
// is taken while it waits. Clearing the histories is immediate: per-entry valid bits make
// cleared entries read as zero. tap_count 0 acts as 1 and values above MAX_TAPS act as
// MAX_TAPS. Coefficients must be written before they are used.
module iir_filter_direct_form_one_top
   import iirdf1_pkg::*;
#(
   parameter int MAX_TAPS = DEF_MAX_TAPS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_wr_en,
   input  logic [TAP_CFG_W-1:0] csr_wr_data
);

   localparam int IDX_W = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int LEN_W = $clog2(MAX_TAPS + 1);
   localparam int AW    = IDX_W + 1;
   localparam int ACC_W = 2 * DATA_W + $clog2(2 * MAX_TAPS);

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_MAC   = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   // which product sum the walk is on
   typedef enum logic [1:0] {
      PH_B  = 2'd0,
      PH_A  = 2'd1,
      PH_A0 = 2'd2
   } phase_type;

   state_type state_ff, state_in;
   phase_type phase_ff;

   logic [TAP_CFG_W-1:0] tap_count_ff;
   logic [LEN_W-1:0]     len_eff, len_ff, len_m1;
   logic [IDX_W-1:0]     pos_ff, pos_eff, pos_next;
   logic [IDX_W-1:0]     i_ff, r_ff, r_step;

   // pipeline of the multiply-accumulate
   logic                 s1_vld_ff, s1_neg_ff, s1_a0_ff;
   logic                 s2_vld_ff, s2_neg_ff;
   logic signed [2*DATA_W-1:0] prod_ff;
   logic [ACC_W-1:0]     acc_ff, prod_ext, acc_mag;
   logic [DATA_W-1:0]    a0_ff, a0_mag;

   logic [DATA_W-1:0]    res_ff;
   logic                 sat_ff, zd_ff, neg_res_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff;

   // memory ports
   logic                 hist_wr_en, hist_clear;
   logic [AW-1:0]        hist_wr_addr, hist_rd_addr;
   logic [DATA_W-1:0]    hist_wr_data, hist_rd_data;
   logic                 coef_wr_en;
   logic [AW-1:0]        coef_wr_addr, coef_rd_addr;
   logic [DATA_W-1:0]    coef_rd_data;

   div_ctl_type          div_ctl;
   logic                 div_done;
   logic [ACC_W-1:0]     div_quo;
   logic [DATA_W-1:0]    lim;
   logic                 over;

   logic                 acc_item, is_sample, is_coef, is_clear, mac_empty, out_go;

   // handshake and item decode
   assign req_ready = (state_ff == ST_IDLE);
   assign acc_item  = req_valid && req_ready;
   assign is_sample = acc_item && (req_data.kind == KIND_SAMPLE);
   assign is_clear  = acc_item && (req_data.kind == KIND_CLEAR);
   assign is_coef   = acc_item && ((req_data.kind == KIND_B_COEF) ||
                                   (req_data.kind == KIND_A_COEF)) &&
                      (int'(req_data.coef_index) < MAX_TAPS);

   // effective ring length and position
   always_comb begin
      if (tap_count_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (int'(tap_count_ff) > MAX_TAPS) begin
         len_eff = LEN_W'(MAX_TAPS);
      end else begin
         len_eff = LEN_W'(tap_count_ff);
      end
   end
   assign pos_eff  = (LEN_W'(pos_ff) >= len_eff) ? '0 : pos_ff;
   assign len_m1   = len_ff - 1'b1;
   assign pos_next = ((LEN_W'(pos_ff) + 1'b1) >= len_ff) ? '0 : pos_ff + 1'b1;
   assign r_step   = (r_ff == '0) ? IDX_W'(len_m1) : r_ff - 1'b1;

   assign mac_empty = !s1_vld_ff && !s2_vld_ff;
   assign out_go    = !rsp_valid_ff || rsp_ready;

   // history port: x[n] at accept, y[n] when the result goes out
   assign hist_clear   = is_clear;
   assign hist_wr_en   = is_sample || (state_ff == ST_OUT && out_go);
   assign hist_wr_addr = is_sample ? {1'b0, pos_eff} : {1'b1, pos_ff};
   assign hist_wr_data = is_sample ? req_data.sample : res_ff;
   assign hist_rd_addr = {phase_ff == PH_A, r_ff};

   assign coef_wr_en   = is_coef;
   assign coef_wr_addr = {req_data.kind == KIND_A_COEF, IDX_W'(req_data.coef_index)};
   assign coef_rd_addr = {phase_ff != PH_B, (phase_ff == PH_A0) ? IDX_W'(0) : i_ff};

   iirdf1_hist_mem #(.AW(AW)) u_hist (
      .clock   (clock),
      .reset   (reset),
      .clear   (hist_clear),
      .wr_en   (hist_wr_en),
      .wr_addr (hist_wr_addr),
      .wr_data (hist_wr_data),
      .rd_addr (hist_rd_addr),
      .rd_data (hist_rd_data)
   );

   iirdf1_coef_mem #(.AW(AW)) u_coef (
      .clock   (clock),
      .wr_en   (coef_wr_en),
      .wr_addr (coef_wr_addr),
      .wr_data (req_data.coef_value),
      .rd_addr (coef_rd_addr),
      .rd_data (coef_rd_data)
   );

   // magnitudes for the divider
   assign acc_mag        = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;
   assign a0_mag         = a0_ff[DATA_W-1] ? DATA_W'(-a0_ff) : a0_ff;
   assign div_ctl.start  = (state_ff == ST_DRAIN) && mac_empty && (a0_ff != '0);
   assign div_ctl.divisor = a0_mag;

   iirdf1_divider #(.ACC_W(ACC_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend (acc_mag),
      .done     (div_done),
      .quotient (div_quo)
   );

   // clip test on the quotient magnitude
   assign lim  = neg_res_ff ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
   assign over = (|div_quo[ACC_W-1:DATA_W]) || (div_quo[DATA_W-1:0] > lim);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (is_sample) state_in = ST_MAC;
         ST_MAC:   if (phase_ff == PH_A0) state_in = ST_DRAIN;
         ST_DRAIN: if (mac_empty) state_in = (a0_ff == '0) ? ST_OUT : ST_DIV;
         ST_DIV:   if (div_done) state_in = ST_OUT;
         ST_OUT:   if (out_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tap_count_ff <= TAP_CFG_W'(1);
         pos_ff       <= '0;
         s1_vld_ff    <= 1'b0;
         s1_a0_ff     <= 1'b0;
         s2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            tap_count_ff <= csr_wr_data;
         end
         if (is_clear) begin
            pos_ff <= '0;
         end else if (is_sample) begin
            pos_ff <= pos_eff;
         end else if (state_ff == ST_OUT && out_go) begin
            pos_ff <= pos_next;
         end
         s1_vld_ff <= (state_ff == ST_MAC);
         s1_a0_ff  <= (state_ff == ST_MAC) && (phase_ff == PH_A0);
         s2_vld_ff <= s1_vld_ff && !s1_a0_ff;
         if (state_ff == ST_OUT && out_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // walk over the rings and the datapath
   assign prod_ext = {{(ACC_W-2*DATA_W){prod_ff[2*DATA_W-1]}}, prod_ff};

   always_ff @(posedge clock) begin
      if (is_sample) begin
         len_ff   <= len_eff;
         phase_ff <= PH_B;
         i_ff     <= '0;
         r_ff     <= pos_eff;
         acc_ff   <= '0;
      end else if (state_ff == ST_MAC) begin
         case (phase_ff)
            PH_B: begin
               if (LEN_W'(i_ff) == len_m1) begin
                  phase_ff <= (len_m1 == '0) ? PH_A0 : PH_A;
                  i_ff     <= IDX_W'(1);
                  r_ff     <= (pos_ff == '0) ? IDX_W'(len_m1) : pos_ff - 1'b1;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  r_ff <= r_step;
               end
            end
            PH_A: begin
               if (LEN_W'(i_ff) == len_m1) begin
                  phase_ff <= PH_A0;
               end else begin
                  i_ff <= i_ff + 1'b1;
                  r_ff <= r_step;
               end
            end
            default: phase_ff <= PH_B;
         endcase
      end

      // stage one: memory data in, multiply or take a[0]
      s1_neg_ff <= (phase_ff == PH_A);
      if (s1_vld_ff && s1_a0_ff) begin
         a0_ff <= coef_rd_data;
      end
      prod_ff   <= $signed(hist_rd_data) * $signed(coef_rd_data);
      s2_neg_ff <= s1_neg_ff;

      // stage two: accumulate
      if (s2_vld_ff) begin
         acc_ff <= s2_neg_ff ? acc_ff - prod_ext : acc_ff + prod_ext;
      end

      if (state_ff == ST_DRAIN && mac_empty) begin
         neg_res_ff <= acc_ff[ACC_W-1] ^ a0_ff[DATA_W-1];
         res_ff     <= '0;
         sat_ff     <= 1'b0;
         zd_ff      <= (a0_ff == '0);
      end else if (state_ff == ST_DIV && div_done) begin
         if (over) begin
            sat_ff <= 1'b1;
            res_ff <= lim;
         end else begin
            res_ff <= neg_res_ff ? DATA_W'(-div_quo[DATA_W-1:0]) : div_quo[DATA_W-1:0];
         end
      end

      if (state_ff == ST_OUT && out_go) begin
         rsp_data_ff.filtered     <= res_ff;
         rsp_data_ff.saturated    <= sat_ff;
         rsp_data_ff.zero_divisor <= zd_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result appears only from the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output state");

   // clip and zero-divisor flags exclude each other
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.saturated && rsp_data_ff.zero_divisor))
      else $error("saturated and zero_divisor both set");

   // divider finishes only while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV))
      else $error("divider done outside the divide state");

   // accumulate stage holds no product whenever a new item can enter
   a_mac_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !s2_vld_ff)
      else $error("accumulate pipeline busy while idle");

endmodule

>>> hdl/iirdf1_hist_mem.sv
// history memory: input ring in the lower half, output ring in the upper half
module iirdf1_hist_mem
   import iirdf1_pkg::*;
#(
   parameter int AW = 7
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              clear,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**AW];
   logic [2**AW-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // unwritten or cleared entries read as zero
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

>>> hdl/iirdf1_coef_mem.sv
// coefficient memory: b table in the lower half, a table in the upper half
module iirdf1_coef_mem
   import iirdf1_pkg::*;
#(
   parameter int AW = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [AW-1:0]     rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [2**AW];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/iirdf1_divider.sv
// restoring divider, one quotient bit per cycle
module iirdf1_divider
   import iirdf1_pkg::*;
#(
   parameter int ACC_W = 71
) (
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [ACC_W-1:0]  dividend,
   output logic              done,
   output logic [ACC_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(ACC_W);

   logic [DATA_W-1:0] rem_ff;
   logic [DATA_W-1:0] div_ff;
   logic [ACC_W-1:0]  quo_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   diff;

   assign rem_sh = {rem_ff, quo_ff[ACC_W-1]};
   assign diff   = rem_sh - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         rem_ff <= '0;
         div_ff <= ctl.divisor;
         quo_ff <= dividend;
      end else if (busy_ff) begin
         if (!diff[DATA_W]) begin
            rem_ff <= diff[DATA_W-1:0];
            quo_ff <= {quo_ff[ACC_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DATA_W-1:0];
            quo_ff <= {quo_ff[ACC_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ACC_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
